// ===== rtl/c8exe_pkg.sv =====
// Shared types and constants of the CHIP-8 instruction execute unit.
`timescale 1ns / 1ps
`default_nettype none

package c8exe_pkg;

	// Field widths of the instruction and result channels.
	localparam int OPCODE_W  = 16;
	localparam int BYTE_W    = 8;
	localparam int INDEX_W   = 16;
	localparam int NEXT_PC_W = 12;
	localparam int NREGS     = 16;
	localparam int REG_IDX_W = 4;

	// Program start address after reset.
	localparam logic [15:0] PC_START = 16'h0200;

	// Whole-word system instructions.
	localparam logic [OPCODE_W-1:0] OP_CLS = 16'h00E0;
	localparam logic [OPCODE_W-1:0] OP_RET = 16'h00EE;

	// The flag register VF.
	localparam logic [REG_IDX_W-1:0] FLAG_REG = 4'hF;

	// Instruction groups, selected by the top nibble of the opcode.
	typedef enum logic [3:0] {
		GRP_SYS     = 4'h0,
		GRP_JP      = 4'h1,
		GRP_CALL    = 4'h2,
		GRP_SE_IMM  = 4'h3,
		GRP_SNE_IMM = 4'h4,
		GRP_SE_REG  = 4'h5,
		GRP_LD_IMM  = 4'h6,
		GRP_ADD_IMM = 4'h7,
		GRP_ALU     = 4'h8,
		GRP_SNE_REG = 4'h9,
		GRP_LD_I    = 4'hA,
		GRP_JP_V0   = 4'hB,
		GRP_RND     = 4'hC,
		GRP_DRW     = 4'hD,
		GRP_SKP     = 4'hE,
		GRP_MISC    = 4'hF
	} grp_t;

	// ALU operations, selected by the low nibble of an 8xyN instruction.
	typedef enum logic [3:0] {
		ALU_LD   = 4'h0,
		ALU_OR   = 4'h1,
		ALU_AND  = 4'h2,
		ALU_XOR  = 4'h3,
		ALU_ADD  = 4'h4,
		ALU_SUB  = 4'h5,
		ALU_SHR  = 4'h6,
		ALU_SUBN = 4'h7,
		ALU_SHL  = 4'hE
	} alu_t;

	// Fxkk sub-operations, selected by the low byte.
	localparam logic [7:0] FOP_LD_VX_DT = 8'h07;
	localparam logic [7:0] FOP_LD_DT    = 8'h15;
	localparam logic [7:0] FOP_LD_ST    = 8'h18;
	localparam logic [7:0] FOP_ADD_I    = 8'h1E;

endpackage

`default_nettype wire

// ===== rtl/chip8_instruction_execute_unit.sv =====
// CHIP-8 instruction execute unit: register file, stack, timers and program counter.
`timescale 1ns / 1ps
`default_nettype none

// Executes one CHIP-8 instruction per transfer on the input channel, fetched
// outside at the address last shown on next_pc (0x200 after reset). A transfer
// loads the instruction and its two byte-register operands into the input
// register; it executes from there into the result register once that register is
// free or being taken, and a new instruction can be taken every cycle while the
// output does not stall. The sustained rate of one instruction per cycle is set
// by the loop from the architectural state through the execute logic
// and back. Operand reads forward the writes of the instruction executing in the
// same cycle, so dependent instructions may follow each other directly. The
// outputs show the state after the instruction; CLS appears as a one-result
// pulse on clear_display, and drawing, key, BCD, font and memory transfer
// instructions are flagged on unsupported and only advance the program counter.
// Program counter and stack pointer wrap. There is no clearing pass after reset.
module chip8_instruction_execute_unit #(
	parameter int STACK_DEPTH = 16,
	parameter int ADDR_BITS   = 12
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [c8exe_pkg::OPCODE_W-1:0]        opcode,
	input  wire  [c8exe_pkg::BYTE_W-1:0]          random_byte,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [c8exe_pkg::NEXT_PC_W-1:0]       next_pc,
	output logic                                  clear_display,
	output logic [c8exe_pkg::INDEX_W-1:0]         index_value,
	output logic [c8exe_pkg::BYTE_W-1:0]          delay_value,
	output logic [c8exe_pkg::BYTE_W-1:0]          sound_value,
	output logic                                  unsupported
);

	import c8exe_pkg::*;

	localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

	// Handshake state.
	logic                 s1_valid_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 exec_go;

	// Input register.
	logic [OPCODE_W-1:0]  op_s1;
	logic [BYTE_W-1:0]    rnd_s1;
	logic [BYTE_W-1:0]    vx_s1;
	logic [BYTE_W-1:0]    vy_s1;

	// Architectural state.
	logic [ADDR_BITS-1:0] pc_q;
	logic [INDEX_W-1:0]   index_q;
	logic [BYTE_W-1:0]    delay_q;
	logic [BYTE_W-1:0]    sound_q;
	logic [SP_W-1:0]      sp_q;
	logic [ADDR_BITS-1:0] tos_q;
	logic [BYTE_W-1:0]    vf_q;
	logic [BYTE_W-1:0]    v0_q;
	logic [NREGS-1:0]     rf_vld_q;
	logic [BYTE_W-1:0]    rf_mem [NREGS];
	logic [ADDR_BITS-1:0] stack_mem [STACK_DEPTH];

	// Result register.
	logic                 cls_q;
	logic                 unsup_q;

	// Decoded fields.
	grp_t                 grp;
	alu_t                 alu;
	logic [REG_IDX_W-1:0] x_s1;
	logic [7:0]           kk;
	logic [11:0]          nnn;

	// Execute results.
	logic [ADDR_BITS-1:0] pc_inc;
	logic [ADDR_BITS-1:0] pc_skip;
	logic [ADDR_BITS-1:0] pc_nnn;
	logic [ADDR_BITS-1:0] pc_v0;
	logic [ADDR_BITS-1:0] pc_d;
	logic [SP_W-1:0]      sp_inc;
	logic [SP_W-1:0]      sp_dec;
	logic [SP_W-1:0]      sp_d;
	logic [SP_W-1:0]      sp_rd;
	logic                 push;
	logic [INDEX_W-1:0]   index_d;
	logic [BYTE_W-1:0]    delay_d;
	logic [BYTE_W-1:0]    sound_d;
	logic                 wr_vx;
	logic [BYTE_W-1:0]    res;
	logic                 flag_we;
	logic                 flag;
	logic                 flag_last;
	logic                 cls;
	logic                 unsup;
	logic                 x_is_f;
	logic                 rf_we;
	logic                 vf_we;
	logic [BYTE_W-1:0]    vf_wd;
	logic [BYTE_W-1:0]    vf_next;

	// Operand read addresses of the arriving instruction and their forwarding hits.
	logic [REG_IDX_W-1:0] in_x;
	logic [REG_IDX_W-1:0] in_y;
	logic                 hit_x;
	logic                 hit_y;

	// Flow control: the input register empties into the result register.
	assign exec_go  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !exec_go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (exec_go) begin
				s1_valid_q <= 1'b0;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Field decode.
	assign grp  = grp_t'(op_s1[15:12]);
	assign alu  = alu_t'(op_s1[3:0]);
	assign x_s1 = op_s1[11:8];
	assign kk   = op_s1[7:0];
	assign nnn  = op_s1[11:0];

	// Program counter and stack pointer candidates.
	assign pc_inc  = pc_q + ADDR_BITS'(2);
	assign pc_skip = pc_q + ADDR_BITS'(4);
	assign pc_nnn  = ADDR_BITS'(nnn);
	assign pc_v0   = pc_nnn + ADDR_BITS'(v0_q);
	assign sp_inc  = (sp_q == SP_LAST) ? '0 : sp_q + SP_W'(1);
	assign sp_dec  = (sp_q == '0) ? SP_LAST : sp_q - SP_W'(1);
	assign sp_rd   = (sp_d == '0) ? SP_LAST : sp_d - SP_W'(1);

	// Instruction execute.
	always_comb begin
		pc_d      = pc_inc;
		sp_d      = sp_q;
		push      = 1'b0;
		index_d   = index_q;
		delay_d   = delay_q;
		sound_d   = sound_q;
		wr_vx     = 1'b0;
		res       = vx_s1;
		flag_we   = 1'b0;
		flag      = 1'b0;
		flag_last = 1'b0;
		cls       = 1'b0;
		unsup     = 1'b0;
		case (grp)
			GRP_SYS: begin
				if (op_s1 == OP_CLS) begin
					cls = 1'b1;
				end else if (op_s1 == OP_RET) begin
					sp_d = sp_dec;
					pc_d = tos_q;
				end else begin
					unsup = 1'b1;
				end
			end
			GRP_JP: begin
				pc_d = pc_nnn;
			end
			GRP_CALL: begin
				push = 1'b1;
				sp_d = sp_inc;
				pc_d = pc_nnn;
			end
			GRP_SE_IMM: begin
				if (vx_s1 == kk) pc_d = pc_skip;
			end
			GRP_SNE_IMM: begin
				if (vx_s1 != kk) pc_d = pc_skip;
			end
			GRP_SE_REG: begin
				if (vx_s1 == vy_s1) pc_d = pc_skip;
			end
			GRP_SNE_REG: begin
				if (vx_s1 != vy_s1) pc_d = pc_skip;
			end
			GRP_LD_IMM: begin
				wr_vx = 1'b1;
				res   = kk;
			end
			GRP_ADD_IMM: begin
				wr_vx = 1'b1;
				res   = vx_s1 + kk;
			end
			GRP_ALU: begin
				wr_vx = 1'b1;
				case (alu)
					ALU_LD:  res = vy_s1;
					ALU_OR:  res = vx_s1 | vy_s1;
					ALU_AND: res = vx_s1 & vy_s1;
					ALU_XOR: res = vx_s1 ^ vy_s1;
					ALU_ADD: begin
						{flag, res} = {1'b0, vx_s1} + {1'b0, vy_s1};
						flag_we     = 1'b1;
						flag_last   = 1'b1;
					end
					ALU_SUB: begin
						res     = vx_s1 - vy_s1;
						flag    = vx_s1 > vy_s1;
						flag_we = 1'b1;
					end
					ALU_SHR: begin
						res     = {1'b0, vx_s1[7:1]};
						flag    = vx_s1[0];
						flag_we = 1'b1;
					end
					ALU_SUBN: begin
						res     = vy_s1 - vx_s1;
						flag    = vy_s1 > vx_s1;
						flag_we = 1'b1;
					end
					ALU_SHL: begin
						res     = {vx_s1[6:0], 1'b0};
						flag    = vx_s1[7];
						flag_we = 1'b1;
					end
					default: begin
						wr_vx = 1'b0;
						unsup = 1'b1;
					end
				endcase
			end
			GRP_LD_I: begin
				index_d = INDEX_W'(nnn);
			end
			GRP_JP_V0: begin
				pc_d = pc_v0;
			end
			GRP_RND: begin
				wr_vx = 1'b1;
				res   = kk & rnd_s1;
			end
			GRP_MISC: begin
				case (kk)
					FOP_LD_VX_DT: begin
						wr_vx = 1'b1;
						res   = delay_q;
					end
					FOP_LD_DT:    delay_d = vx_s1;
					FOP_LD_ST:    sound_d = vx_s1;
					FOP_ADD_I:    index_d = index_q + INDEX_W'(vx_s1);
					default:      unsup = 1'b1;
				endcase
			end
			default: begin
				unsup = 1'b1;
			end
		endcase
	end

	// Register write resolution. For ADD the carry lands in VF after the sum;
	// for the other flag operations the result lands in VF after the flag.
	assign x_is_f  = (x_s1 == FLAG_REG);
	assign rf_we   = wr_vx && !x_is_f;
	assign vf_we   = flag_we || (wr_vx && x_is_f);
	assign vf_wd   = (wr_vx && x_is_f && !flag_last) ? res :
	                 (flag_we ? BYTE_W'(flag) : res);
	assign vf_next = (exec_go && vf_we) ? vf_wd : vf_q;

	// Operand forwarding for the instruction arriving in this cycle.
	assign in_x  = opcode[11:8];
	assign in_y  = opcode[7:4];
	assign hit_x = exec_go && rf_we && (x_s1 == in_x);
	assign hit_y = exec_go && rf_we && (x_s1 == in_y);

	// Input register and V0..VE register file with registered reads.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			rnd_s1 <= random_byte;
			if (in_x == FLAG_REG) begin
				vx_s1 <= vf_next;
			end else if (hit_x) begin
				vx_s1 <= res;
			end else if (!rf_vld_q[in_x]) begin
				vx_s1 <= '0;
			end else begin
				vx_s1 <= rf_mem[in_x];
			end
			if (in_y == FLAG_REG) begin
				vy_s1 <= vf_next;
			end else if (hit_y) begin
				vy_s1 <= res;
			end else if (!rf_vld_q[in_y]) begin
				vy_s1 <= '0;
			end else begin
				vy_s1 <= rf_mem[in_y];
			end
		end
		if (exec_go && rf_we) begin
			rf_mem[x_s1] <= res;
		end
	end

	// Return stack with the top entry held in a registered read.
	always_ff @(posedge clk) begin
		if (exec_go) begin
			if (push) begin
				stack_mem[sp_q] <= pc_inc;
				tos_q           <= pc_inc;
			end else begin
				tos_q <= stack_mem[sp_rd];
			end
		end
	end

	// Architectural state and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= ADDR_BITS'(PC_START);
			index_q  <= '0;
			delay_q  <= '0;
			sound_q  <= '0;
			sp_q     <= '0;
			vf_q     <= '0;
			v0_q     <= '0;
			rf_vld_q <= '0;
			cls_q    <= 1'b0;
			unsup_q  <= 1'b0;
		end else if (exec_go) begin
			pc_q    <= pc_d;
			index_q <= index_d;
			delay_q <= delay_d;
			sound_q <= sound_d;
			sp_q    <= sp_d;
			vf_q    <= vf_wd & {BYTE_W{vf_we}} | vf_q & {BYTE_W{!vf_we}};
			if (rf_we) begin
				rf_vld_q[x_s1] <= 1'b1;
				if (x_s1 == '0) v0_q <= res;
			end
			cls_q   <= cls;
			unsup_q <= unsup;
		end
	end

	// The result shows the state after the instruction; it only changes on execute.
	assign out_valid     = out_valid_q;
	assign next_pc       = pc_q[NEXT_PC_W-1:0];
	assign clear_display = cls_q;
	assign index_value   = index_q;
	assign delay_value   = delay_q;
	assign sound_value   = sound_q;
	assign unsupported   = unsup_q;

endmodule

`default_nettype wire

// ===== rtl/c8exe_port_checker.sv =====
// Port-level assertion checker for the CHIP-8 instruction execute unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module c8exe_port_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_stall,
	input wire [c8exe_pkg::OPCODE_W-1:0]       opcode,
	input wire [c8exe_pkg::BYTE_W-1:0]         random_byte,
	input wire                                 out_valid,
	input wire                                 out_stall,
	input wire [c8exe_pkg::NEXT_PC_W-1:0]      next_pc,
	input wire                                 clear_display,
	input wire [c8exe_pkg::INDEX_W-1:0]        index_value,
	input wire [c8exe_pkg::BYTE_W-1:0]         delay_value,
	input wire [c8exe_pkg::BYTE_W-1:0]         sound_value,
	input wire                                 unsupported
);

	import c8exe_pkg::*;

	logic                  in_xfer;
	logic                  out_xfer;
	logic [1:0]            pending_q;
	logic [NEXT_PC_W-1:0]  prev_pc_q;
	logic [INDEX_W-1:0]    prev_index_q;
	logic [BYTE_W-1:0]     prev_delay_q;
	logic [BYTE_W-1:0]     prev_sound_q;
	logic                  in_seen;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	// The payload is sampled here only so that every port of the block is observed.
	assign in_seen  = |{opcode, random_byte};

	// Track instructions in flight and the state shown by the last result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			prev_pc_q    <= PC_START[NEXT_PC_W-1:0];
			prev_index_q <= '0;
			prev_delay_q <= '0;
			prev_sound_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_xfer) - 2'(out_xfer);
			if (out_xfer) begin
				prev_pc_q    <= next_pc;
				prev_index_q <= index_value;
				prev_delay_q <= delay_value;
				prev_sound_q <= sound_value;
			end
		end
	end

	// A held result keeps its program counter, index and flags until it is transferred.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc) &&
		$stable(index_value) && $stable(unsupported) && $stable(clear_display))
		else $error("result changed while stalled");

	// Every result transfer is paid for by an earlier or simultaneous instruction transfer.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pending_q != 2'd0 || in_xfer && in_seen || in_xfer)
		else $error("result without a pending instruction");

	// An unsupported instruction only advances the program counter.
	a_unsup_noop: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && unsupported |-> next_pc == prev_pc_q + 12'd2 &&
		index_value == prev_index_q && delay_value == prev_delay_q &&
		sound_value == prev_sound_q)
		else $error("unsupported instruction changed state");

	// CLS is a supported instruction that falls through to the next word.
	a_cls_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && clear_display |-> !unsupported && next_pc == prev_pc_q + 12'd2 &&
		index_value == prev_index_q)
		else $error("clear display with wrong program counter or flags");

endmodule

bind chip8_instruction_execute_unit c8exe_port_checker u_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.opcode        (opcode),
	.random_byte   (random_byte),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.next_pc       (next_pc),
	.clear_display (clear_display),
	.index_value   (index_value),
	.delay_value   (delay_value),
	.sound_value   (sound_value),
	.unsupported   (unsupported)
);

`default_nettype wire
